[rtl/aalr_pkg.sv]
package aalr_pkg;

    // Default geometry and precision of the line walker
    localparam int COORD_BITS_DEF    = 10;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int SHADE_BITS_DEF    = 3;

    // Width of a palette index
    localparam int COLOR_BITS = 8;

    // Walker modes
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_VERT = 3'd1,
        MODE_HORZ = 3'd2,
        MODE_DIAG = 3'd3,
        MODE_XMAJ = 3'd4,
        MODE_YMAJ = 3'd5
    } t_walk_mode;

    // Sequencer states
    typedef enum logic [0:0] {
        ST_IDLE   = 1'b0,
        ST_DIVIDE = 1'b1
    } t_state;

    // Handshake between sequencer and slope divider
    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic done;
    } t_div_stat;

endpackage

[rtl/aalr_in_if.sv]
interface aalr_in_if #(
    parameter int COORD_BITS = aalr_pkg::COORD_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [COORD_BITS-1:0]           start_x;
    logic [COORD_BITS-1:0]           start_y;
    logic [COORD_BITS-1:0]           end_x;
    logic [COORD_BITS-1:0]           end_y;
    logic [aalr_pkg::COLOR_BITS-1:0] base_color;

    modport source (
        output valid, kind, start_x, start_y, end_x, end_y, base_color,
        input  ready
    );

    modport sink (
        input  valid, kind, start_x, start_y, end_x, end_y, base_color,
        output ready
    );
endinterface

[rtl/aalr_out_if.sv]
interface aalr_out_if #(
    parameter int COORD_BITS = aalr_pkg::COORD_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic                            write_a;
    logic signed [COORD_BITS+1:0]    x_a;
    logic [COORD_BITS:0]             y_a;
    logic [aalr_pkg::COLOR_BITS-1:0] color_a;
    logic                            write_b;
    logic signed [COORD_BITS+1:0]    x_b;
    logic [COORD_BITS:0]             y_b;
    logic [aalr_pkg::COLOR_BITS-1:0] color_b;
    logic                            last;

    modport source (
        output valid, write_a, x_a, y_a, color_a, write_b, x_b, y_b, color_b, last,
        input  ready
    );

    modport sink (
        input  valid, write_a, x_a, y_a, color_a, write_b, x_b, y_b, color_b, last,
        output ready
    );
endinterface

[rtl/aalr_divider.sv]
module aalr_divider #(
    parameter int COORD_BITS    = aalr_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = aalr_pkg::FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  aalr_pkg::t_div_ctrl      i_ctrl,
    input  logic [COORD_BITS-1:0]    i_dividend,
    input  logic [COORD_BITS-1:0]    i_divisor,
    output aalr_pkg::t_div_stat      o_stat,
    output logic [FRACTION_BITS-1:0] o_quotient
);
    // Restoring division of (dividend << FRACTION_BITS) by divisor,
    // one quotient bit a cycle; dividend is below divisor on entry.
    localparam int CNT_W = $clog2(FRACTION_BITS + 1);

    logic [COORD_BITS-1:0]    r_rem, n_rem;
    logic [COORD_BITS-1:0]    r_den;
    logic [FRACTION_BITS-1:0] r_quo, n_quo;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_done, n_done;

    logic [COORD_BITS:0]      w_rem2;
    logic [COORD_BITS:0]      w_diff;
    logic                     w_take;

    // Shift and trial subtract
    assign w_rem2 = {r_rem, 1'b0};
    assign w_diff = w_rem2 - {1'b0, r_den};
    assign w_take = (w_rem2 >= {1'b0, r_den});

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_ctrl.start) begin
            n_rem = i_dividend;
            n_quo = '0;
            n_cnt = CNT_W'(FRACTION_BITS);
        end else if (r_cnt != '0) begin
            n_rem  = w_take ? w_diff[COORD_BITS-1:0] : w_rem2[COORD_BITS-1:0];
            n_quo  = {r_quo[FRACTION_BITS-2:0], w_take};
            n_cnt  = r_cnt - CNT_W'(1);
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_ctrl.start) begin
            r_den <= i_divisor;
        end
    end

    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
endmodule

[rtl/antialiased_line_rasterizer.sv]
// Step request: result registered on acceptance; one request a cycle unless stalled.
// Load request: first pixel is registered on acceptance. A Wu-slope
// load then keeps the block busy until the serial slope divider, which
// produces one quotient bit a cycle, is done.
// Reset (synchronous, active low) idles the walker and clears all walker state.
module antialiased_line_rasterizer #(
    parameter int COORD_BITS    = aalr_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = aalr_pkg::FRACTION_BITS_DEF,
    parameter int SHADE_BITS    = aalr_pkg::SHADE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aalr_in_if.sink    i_req,
    aalr_out_if.source o_res
);
    localparam int CB = aalr_pkg::COLOR_BITS;
    localparam int XW = COORD_BITS + 2;
    localparam int YW = COORD_BITS + 1;
    localparam logic [SHADE_BITS-1:0] SHADE_MAX = {SHADE_BITS{1'b1}};

    // Sequencer and walker state
    aalr_pkg::t_state     r_state, n_state;
    aalr_pkg::t_walk_mode r_mode, n_mode;
    logic [COORD_BITS-1:0]    r_cursor_x, n_cursor_x;
    logic [COORD_BITS-1:0]    r_cursor_y, n_cursor_y;
    logic [COORD_BITS-1:0]    r_finish_x, n_finish_x;
    logic [COORD_BITS-1:0]    r_finish_y, n_finish_y;
    logic [FRACTION_BITS-1:0] r_acc, n_acc;
    logic [FRACTION_BITS-1:0] r_step, n_step;
    logic                     r_dir, n_dir;
    logic [COORD_BITS-1:0]    r_steps, n_steps;
    logic [CB-1:0]            r_color, n_color;

    // Output register
    logic                 r_out_valid, n_out_valid;
    logic                 r_write_a, n_write_a;
    logic signed [XW-1:0] r_x_a, n_x_a;
    logic [YW-1:0]        r_y_a, n_y_a;
    logic [CB-1:0]        r_color_a, n_color_a;
    logic                 r_write_b, n_write_b;
    logic signed [XW-1:0] r_x_b, n_x_b;
    logic [YW-1:0]        r_y_b, n_y_b;
    logic [CB-1:0]        r_color_b, n_color_b;
    logic                 r_last, n_last;
    logic                 w_have_res;

    logic                 w_ready;
    logic                 w_accept;
    aalr_pkg::t_div_ctrl  w_div_ctrl;
    aalr_pkg::t_div_stat  w_div_stat;
    logic [FRACTION_BITS-1:0] w_quotient;

    // Load setup signals
    logic                  w_swap;
    logic [COORD_BITS-1:0] w_x1, w_y1, w_x2, w_y2;
    logic [COORD_BITS:0]   w_ddx;
    logic                  w_neg;
    logic [COORD_BITS-1:0] w_adx, w_ddy;
    aalr_pkg::t_walk_mode  w_ld_mode;
    logic [COORD_BITS-1:0] w_ld_steps;
    logic [COORD_BITS-1:0] w_ld_cx;
    logic [COORD_BITS-1:0] w_minor, w_major;
    logic                  w_ld_wu;

    // Step signals
    logic [COORD_BITS-1:0]    w_steps_dec;
    logic                     w_step_last;
    logic [FRACTION_BITS:0]   w_sum;
    logic [FRACTION_BITS-1:0] w_acc_new;
    logic [SHADE_BITS-1:0]    w_shade;
    logic [COORD_BITS-1:0]    w_cx_inc;
    logic [COORD_BITS-1:0]    w_cy_inc;
    logic [COORD_BITS-1:0]    w_wu_cx, w_wu_cy;
    logic [XW-1:0]            w_xinc_w;

    assign w_accept = i_req.valid && w_ready;

    // Order endpoints so y ascends and classify the slope
    always_comb begin
        w_swap = (i_req.end_y < i_req.start_y);
        w_x1   = w_swap ? i_req.end_x   : i_req.start_x;
        w_y1   = w_swap ? i_req.end_y   : i_req.start_y;
        w_x2   = w_swap ? i_req.start_x : i_req.end_x;
        w_y2   = w_swap ? i_req.start_y : i_req.end_y;
        w_ddx  = {1'b0, w_x2} - {1'b0, w_x1};
        w_neg  = w_ddx[COORD_BITS];
        w_adx  = w_neg ? (w_x1 - w_x2) : (w_x2 - w_x1);
        w_ddy  = w_y2 - w_y1;
        w_ld_cx = w_x1;
        w_minor = w_ddy;
        w_major = w_adx;
        if (w_adx == '0) begin
            w_ld_mode  = aalr_pkg::MODE_VERT;
            w_ld_steps = w_ddy;
        end else if (w_ddy == '0) begin
            w_ld_mode  = aalr_pkg::MODE_HORZ;
            w_ld_steps = w_adx;
            w_ld_cx    = w_neg ? w_x2 : w_x1;
        end else if (w_adx == w_ddy) begin
            w_ld_mode  = aalr_pkg::MODE_DIAG;
            w_ld_steps = w_ddy;
        end else if (w_adx > w_ddy) begin
            w_ld_mode  = aalr_pkg::MODE_XMAJ;
            w_ld_steps = w_adx;
        end else begin
            w_ld_mode  = aalr_pkg::MODE_YMAJ;
            w_ld_steps = w_ddy;
            w_minor    = w_adx;
            w_major    = w_ddy;
        end
        w_ld_wu = (w_ld_mode == aalr_pkg::MODE_XMAJ) || (w_ld_mode == aalr_pkg::MODE_YMAJ);
    end

    // Advance the accumulator and cursor for one step
    always_comb begin
        w_steps_dec = r_steps - COORD_BITS'(1);
        w_step_last = (w_steps_dec == '0);
        w_sum       = {1'b0, r_acc} + {1'b0, r_step};
        w_acc_new   = w_sum[FRACTION_BITS-1:0];
        w_shade     = w_acc_new[FRACTION_BITS-1 -: SHADE_BITS];
        w_cx_inc    = r_dir ? (r_cursor_x - COORD_BITS'(1)) : (r_cursor_x + COORD_BITS'(1));
        w_cy_inc    = r_cursor_y + COORD_BITS'(1);
        w_xinc_w    = r_dir ? {XW{1'b1}} : XW'(1);
        if (r_mode == aalr_pkg::MODE_XMAJ) begin
            w_wu_cx = w_cx_inc;
            w_wu_cy = w_sum[FRACTION_BITS] ? w_cy_inc : r_cursor_y;
        end else begin
            w_wu_cx = w_sum[FRACTION_BITS] ? w_cx_inc : r_cursor_x;
            w_wu_cy = w_cy_inc;
        end
    end

    // Next walker state and result
    always_comb begin
        n_mode     = r_mode;
        n_cursor_x = r_cursor_x;
        n_cursor_y = r_cursor_y;
        n_finish_x = r_finish_x;
        n_finish_y = r_finish_y;
        n_acc      = r_acc;
        n_step     = r_step;
        n_dir      = r_dir;
        n_steps    = r_steps;
        n_color    = r_color;
        w_have_res = 1'b0;
        n_write_a  = 1'b1;
        n_x_a      = XW'(r_cursor_x);
        n_y_a      = YW'(r_cursor_y);
        n_color_a  = r_color;
        n_write_b  = 1'b0;
        n_x_b      = '0;
        n_y_b      = '0;
        n_color_b  = '0;
        n_last     = 1'b0;
        if (w_accept) begin
            if (!i_req.kind) begin
                n_mode     = (w_ld_steps == '0) ? aalr_pkg::MODE_IDLE : w_ld_mode;
                n_cursor_x = w_ld_cx;
                n_cursor_y = w_y1;
                n_finish_x = w_x2;
                n_finish_y = w_y2;
                n_acc      = '0;
                n_step     = '0;
                n_dir      = w_neg;
                n_steps    = w_ld_steps;
                n_color    = i_req.base_color;
                w_have_res = 1'b1;
                n_x_a      = XW'(w_ld_cx);
                n_y_a      = YW'(w_y1);
                n_color_a  = i_req.base_color;
                n_last     = (w_ld_steps == '0);
            end else if (r_mode == aalr_pkg::MODE_IDLE || r_steps == '0) begin
                n_mode = aalr_pkg::MODE_IDLE;
            end else begin
                n_steps = w_steps_dec;
                case (r_mode)
                    aalr_pkg::MODE_VERT, aalr_pkg::MODE_HORZ, aalr_pkg::MODE_DIAG: begin
                        if (r_mode != aalr_pkg::MODE_VERT) begin
                            n_cursor_x = (r_mode == aalr_pkg::MODE_HORZ)
                                       ? (r_cursor_x + COORD_BITS'(1)) : w_cx_inc;
                        end
                        if (r_mode != aalr_pkg::MODE_HORZ) begin
                            n_cursor_y = w_cy_inc;
                        end
                        w_have_res = 1'b1;
                        n_x_a      = XW'(n_cursor_x);
                        n_y_a      = YW'(n_cursor_y);
                        n_last     = w_step_last;
                        if (w_step_last) begin
                            n_mode = aalr_pkg::MODE_IDLE;
                        end
                    end
                    aalr_pkg::MODE_XMAJ, aalr_pkg::MODE_YMAJ: begin
                        w_have_res = 1'b1;
                        if (w_step_last) begin
                            n_x_a  = XW'(r_finish_x);
                            n_y_a  = YW'(r_finish_y);
                            n_last = 1'b1;
                            n_mode = aalr_pkg::MODE_IDLE;
                        end else begin
                            n_acc      = w_acc_new;
                            n_cursor_x = w_wu_cx;
                            n_cursor_y = w_wu_cy;
                            n_x_a      = XW'(w_wu_cx);
                            n_y_a      = YW'(w_wu_cy);
                            n_color_a  = r_color + CB'(w_shade);
                            n_write_b  = 1'b1;
                            n_color_b  = r_color + CB'(w_shade ^ SHADE_MAX);
                            if (r_mode == aalr_pkg::MODE_XMAJ) begin
                                n_x_b = XW'(w_wu_cx);
                                n_y_b = YW'(w_wu_cy) + YW'(1);
                            end else begin
                                n_x_b = XW'(w_wu_cx) + w_xinc_w;
                                n_y_b = YW'(w_wu_cy);
                            end
                        end
                    end
                    default: begin
                        n_mode     = aalr_pkg::MODE_IDLE;
                        n_steps    = '0;
                        w_have_res = 1'b0;
                    end
                endcase
            end
        end
        // Capture the slope once the divider finishes
        if (r_state == aalr_pkg::ST_DIVIDE && w_div_stat.done) begin
            n_step = w_quotient;
        end
    end

    // Hold the result until the sink takes it
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_have_res) begin
            n_out_valid = 1'b1;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            aalr_pkg::ST_IDLE: begin
                if (w_accept && !i_req.kind && w_ld_wu) begin
                    n_state = aalr_pkg::ST_DIVIDE;
                end
            end
            aalr_pkg::ST_DIVIDE: begin
                if (w_div_stat.done) begin
                    n_state = aalr_pkg::ST_IDLE;
                end
            end
            default: n_state = aalr_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_ready          = 1'b0;
        w_div_ctrl.start = 1'b0;
        case (r_state)
            aalr_pkg::ST_IDLE: begin
                w_ready          = !r_out_valid || o_res.ready;
                w_div_ctrl.start = w_accept && !i_req.kind && w_ld_wu;
            end
            aalr_pkg::ST_DIVIDE: begin
                w_ready = 1'b0;
            end
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    aalr_divider #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_div_ctrl),
        .i_dividend (w_minor),
        .i_divisor  (w_major),
        .o_stat     (w_div_stat),
        .o_quotient (w_quotient)
    );

    // Walker and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aalr_pkg::ST_IDLE;
            r_mode      <= aalr_pkg::MODE_IDLE;
            r_cursor_x  <= '0;
            r_cursor_y  <= '0;
            r_finish_x  <= '0;
            r_finish_y  <= '0;
            r_acc       <= '0;
            r_step      <= '0;
            r_dir       <= 1'b0;
            r_steps     <= '0;
            r_color     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_cursor_x  <= n_cursor_x;
            r_cursor_y  <= n_cursor_y;
            r_finish_x  <= n_finish_x;
            r_finish_y  <= n_finish_y;
            r_acc       <= n_acc;
            r_step      <= n_step;
            r_dir       <= n_dir;
            r_steps     <= n_steps;
            r_color     <= n_color;
            r_out_valid <= n_out_valid;
        end
        if (w_have_res) begin
            r_write_a <= n_write_a;
            r_x_a     <= n_x_a;
            r_y_a     <= n_y_a;
            r_color_a <= n_color_a;
            r_write_b <= n_write_b;
            r_x_b     <= n_x_b;
            r_y_b     <= n_y_b;
            r_color_b <= n_color_b;
            r_last    <= n_last;
        end
    end

    assign i_req.ready   = w_ready;
    assign o_res.valid   = r_out_valid;
    assign o_res.write_a = r_write_a;
    assign o_res.x_a     = r_x_a;
    assign o_res.y_a     = r_y_a;
    assign o_res.color_a = r_color_a;
    assign o_res.write_b = r_write_b;
    assign o_res.x_b     = r_x_b;
    assign o_res.y_b     = r_y_b;
    assign o_res.color_b = r_color_b;
    assign o_res.last    = r_last;
endmodule
